// ===== hw/rtl/frame_slot_flip_pacer_assert.svh =====
// ----------------------------------------------------------------------------
// Frame slot flip pacer assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef FRAME_SLOT_FLIP_PACER_ASSERT_SVH
`define FRAME_SLOT_FLIP_PACER_ASSERT_SVH

// cond holds in a cycle -> expr holds in the same cycle
`define FSFP_ASSERT_IMP(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// cond holds in a cycle -> expr holds in the next cycle
`define FSFP_ASSERT_NEXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== hw/rtl/fsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// fsfp_pkg
// Word types, operation and slot state codes, controller/datapath links.
// ----------------------------------------------------------------------------
package fsfp_pkg;

  localparam int SLOTS        = 4;
  localparam int PERIOD_W     = 20;
  localparam int ELAPSED_W    = 20;
  localparam int FRAME_W      = 24;
  localparam int GEN_W        = 8;
  localparam int SLOT_FIELD_W = 2;
  localparam int LOOPS_W      = 2;
  localparam int LOOP_TOTAL_W = 16;
  localparam int SLOTS_CFG_W  = 3;
  localparam int CFG_DATA_W   = 20;

  localparam logic [SLOTS_CFG_W-1:0] SLOTS_IN_USE_RESET = 3'd4;
  localparam logic [PERIOD_W-1:0]    FRAME_PERIOD_RESET = 20'd33367;

  typedef enum logic [1:0] {
    OP_CLAIM    = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_TICK     = 2'd2,
    OP_RESTART  = 2'd3
  } op_t;

  typedef enum logic {
    CFG_SLOTS_IN_USE = 1'b0,
    CFG_FRAME_PERIOD = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SLOT_EMPTY     = 3'd0,
    SLOT_FILLING   = 3'd1,
    SLOT_QUEUED    = 3'd2,
    SLOT_ON_SCREEN = 3'd3,
    SLOT_PARKED    = 3'd4
  } slot_state_t;

  typedef struct packed {
    op_t                     operation;
    logic [ELAPSED_W-1:0]    elapsed_us;
    logic [SLOT_FIELD_W-1:0] slot_index;
    logic [GEN_W-1:0]        generation_tag;
    logic                    decode_ok;
    logic [FRAME_W-1:0]      frame_number;
    logic                    looped_flag;
  } item_t;

  typedef struct packed {
    logic                    claim_granted;
    logic [SLOT_FIELD_W-1:0] claim_slot;
    logic [GEN_W-1:0]        claim_generation;
    logic                    rewind_decoder;
    logic                    frame_shown;
    logic [SLOT_FIELD_W-1:0] shown_slot;
    logic [FRAME_W-1:0]      latest_frame;
    logic [LOOPS_W-1:0]      loops_seen;
    logic [LOOP_TOTAL_W-1:0] loop_total;
    logic                    playback_ended;
  } result_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic clamp;
    logic pop;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic ended;
    logic below_period;
    logic can_pop;
  } dp_status_t;

endpackage

// ===== hw/rtl/fsfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsfp_ctrl
// Sequencer: capture a word, run its operation, pop due frames, flag result.
// ----------------------------------------------------------------------------
module fsfp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  output logic                 result_valid,
  input  logic                 result_ready,
  output fsfp_pkg::dp_cmd_t    cmd,
  input  fsfp_pkg::dp_status_t status
);
  import fsfp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_CLAMP = 4'b0100,
    ST_POP   = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   done;

  always_comb begin
    state_next = state;
    cmd        = '0;
    done       = 1'b0;
    item_ready = (state == ST_IDLE) && (!result_valid || result_ready);
    case (state)
      ST_IDLE: begin
        if (item_valid && item_ready) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.op == OP_TICK && !status.ended) begin
          state_next = ST_CLAMP;
        end else begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        if (status.below_period) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_POP;
        end
      end
      ST_POP: begin
        if (status.can_pop) begin
          cmd.pop = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (done) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/fsfp_datapath.sv =====
// ----------------------------------------------------------------------------
// fsfp_datapath
// Slot table, ready queue, pacing time and counters, driven by the sequencer.
// ----------------------------------------------------------------------------
module fsfp_datapath #(
  parameter int MAX_CATCH_UP = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  fsfp_pkg::cfg_reg_t                  cfg_index,
  input  logic [fsfp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  fsfp_pkg::item_t                     item,
  input  fsfp_pkg::dp_cmd_t                   cmd,
  output fsfp_pkg::dp_status_t                status,
  output fsfp_pkg::result_t                   result
);
  import fsfp_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int PW = PERIOD_W + $clog2(MAX_CATCH_UP + 1);

  logic [SLOTS_CFG_W-1:0]  slots_in_use;
  logic [PERIOD_W-1:0]     frame_period_us;

  item_t                   held;
  slot_state_t             slot_status [SLOTS];
  logic [FRAME_W-1:0]      slot_frame [SLOTS];
  logic                    slot_loop_mark [SLOTS];
  logic [IW-1:0]           ready_queue [SLOTS];
  logic [IW-1:0]           q_rd_ptr;
  logic [CW-1:0]           q_fill;
  logic [GEN_W-1:0]        generation;
  logic                    restart_pending;
  logic                    end_reached;
  logic                    ended_flag;
  logic [IW-1:0]           displayed_slot;
  logic [IW-1:0]           retired_slot;
  logic                    retired_valid;
  logic [PW-1:0]           pending_us;
  logic [PW:0]             accum_us;
  logic [FRAME_W-1:0]      frame_now;
  logic [LOOP_TOTAL_W-1:0] loop_counter;

  logic                    r_granted;
  logic [IW-1:0]           r_slot;
  logic [GEN_W-1:0]        r_gen;
  logic                    r_rewind;
  logic                    r_shown;
  logic                    r_ended;
  logic                    r_taken;
  logic [LOOPS_W-1:0]      r_loops;
  logic [IW-1:0]           newest;

  logic [PERIOD_W-1:0]     period;
  logic [PW-1:0]           pend_cap;
  logic [PW-1:0]           clamp_value;
  logic [CW-1:0]           usable;
  logic                    claim_found;
  logic [IW-1:0]           claim_idx;
  logic [IW-1:0]           sel_slot;
  logic                    complete_hit;
  logic                    queue_push;
  logic [IW:0]             tail_sum;
  logic [IW-1:0]           tail;
  logic [IW-1:0]           head_inc;
  logic [IW-1:0]           pop_slot;
  logic                    below_period;
  logic                    can_pop;

  always_comb begin
    period      = (frame_period_us == '0) ? PERIOD_W'(1) : frame_period_us;
    pend_cap    = PW'(MAX_CATCH_UP) * PW'(period);
    clamp_value = (accum_us > (PW + 1)'(pend_cap)) ? pend_cap : PW'(accum_us);
    if (int'(slots_in_use) < SLOTS) begin
      usable = CW'(slots_in_use);
    end else begin
      usable = CW'(SLOTS);
    end
    claim_found = 1'b0;
    claim_idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!claim_found && CW'(i) < usable && slot_status[i] == SLOT_EMPTY) begin
        claim_found = 1'b1;
        claim_idx   = IW'(i);
      end
    end
    sel_slot     = IW'(held.slot_index);
    complete_hit = (int'(held.slot_index) < SLOTS) && (slot_status[sel_slot] == SLOT_FILLING);
    queue_push   = cmd.exec && (held.operation == OP_COMPLETE) && complete_hit &&
                   (held.generation_tag == generation) && held.decode_ok;
    tail_sum     = (IW + 1)'(q_rd_ptr) + (IW + 1)'(q_fill);
    tail         = (int'(tail_sum) >= SLOTS) ? IW'(int'(tail_sum) - SLOTS) : IW'(tail_sum);
    head_inc     = (q_rd_ptr == IW'(SLOTS - 1)) ? '0 : q_rd_ptr + 1'b1;
    pop_slot     = ready_queue[q_rd_ptr];
    below_period = accum_us < (PW + 1)'(period);
    can_pop      = (pending_us >= PW'(period)) && (q_fill != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use    <= SLOTS_IN_USE_RESET;
      frame_period_us <= FRAME_PERIOD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SLOTS_IN_USE: slots_in_use    <= cfg_data[SLOTS_CFG_W-1:0];
        CFG_FRAME_PERIOD: frame_period_us <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      held <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (queue_push) begin
      slot_frame[sel_slot]     <= held.frame_number;
      slot_loop_mark[sel_slot] <= held.looped_flag;
      ready_queue[tail]        <= sel_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_status[i] <= (i == 0) ? SLOT_ON_SCREEN : SLOT_EMPTY;
      end
      q_rd_ptr        <= '0;
      q_fill          <= '0;
      generation      <= '0;
      restart_pending <= 1'b0;
      end_reached     <= 1'b0;
      ended_flag      <= 1'b0;
      displayed_slot  <= '0;
      retired_valid   <= 1'b0;
      pending_us      <= '0;
      accum_us        <= '0;
      frame_now       <= '0;
      loop_counter    <= '0;
      r_granted       <= 1'b0;
      r_slot          <= '0;
      r_gen           <= '0;
      r_rewind        <= 1'b0;
      r_shown         <= 1'b0;
      r_ended         <= 1'b0;
      r_taken         <= 1'b0;
      r_loops         <= '0;
    end else begin
      if (cmd.capture) begin
        r_granted <= 1'b0;
        r_slot    <= '0;
        r_gen     <= '0;
        r_rewind  <= 1'b0;
        r_shown   <= 1'b0;
        r_ended   <= 1'b0;
        r_taken   <= 1'b0;
        r_loops   <= '0;
      end

      if (cmd.exec) begin
        case (held.operation)
          OP_CLAIM: begin
            if (restart_pending) begin
              restart_pending <= 1'b0;
              r_rewind        <= 1'b1;
            end else if (!end_reached && claim_found) begin
              slot_status[claim_idx] <= SLOT_FILLING;
              r_granted              <= 1'b1;
              r_slot                 <= claim_idx;
              r_gen                  <= generation;
            end
          end
          OP_COMPLETE: begin
            if (complete_hit) begin
              if (held.generation_tag != generation) begin
                slot_status[sel_slot] <= SLOT_EMPTY;
              end else if (held.decode_ok) begin
                slot_status[sel_slot] <= SLOT_QUEUED;
                q_fill                <= q_fill + 1'b1;
              end else begin
                slot_status[sel_slot] <= SLOT_EMPTY;
                end_reached           <= 1'b1;
              end
            end
          end
          OP_TICK: begin
            if (!ended_flag) begin
              accum_us <= (PW + 1)'(pending_us) + (PW + 1)'(held.elapsed_us);
            end
          end
          OP_RESTART: begin
            generation      <= generation + 1'b1;
            restart_pending <= 1'b1;
            end_reached     <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_status[i] == SLOT_QUEUED) begin
                slot_status[i] <= SLOT_EMPTY;
              end
            end
            q_fill       <= '0;
            frame_now    <= '0;
            pending_us   <= '0;
            loop_counter <= '0;
            ended_flag   <= 1'b0;
          end
          default: ;
        endcase
      end

      if (cmd.clamp) begin
        pending_us <= below_period ? PW'(accum_us) : clamp_value;
      end

      if (cmd.pop) begin
        q_rd_ptr   <= head_inc;
        q_fill     <= q_fill - 1'b1;
        pending_us <= pending_us - PW'(period);
        if (r_taken) begin
          slot_status[newest] <= SLOT_EMPTY;
        end
        newest    <= pop_slot;
        r_taken   <= 1'b1;
        frame_now <= slot_frame[pop_slot];
        if (slot_loop_mark[pop_slot]) begin
          if (loop_counter != '1) begin
            loop_counter <= loop_counter + 1'b1;
          end
          if (r_loops != '1) begin
            r_loops <= r_loops + 1'b1;
          end
        end
      end

      if (cmd.finish) begin
        if (!r_taken) begin
          if (end_reached && q_fill == '0) begin
            ended_flag <= 1'b1;
            pending_us <= '0;
            r_ended    <= 1'b1;
          end
        end else begin
          if (retired_valid) begin
            slot_status[retired_slot] <= SLOT_EMPTY;
          end
          retired_slot                <= displayed_slot;
          retired_valid               <= 1'b1;
          slot_status[displayed_slot] <= SLOT_PARKED;
          displayed_slot              <= newest;
          slot_status[newest]         <= SLOT_ON_SCREEN;
          r_shown                     <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    status.op           = held.operation;
    status.ended        = ended_flag;
    status.below_period = below_period;
    status.can_pop      = can_pop;

    result.claim_granted    = r_granted;
    result.claim_slot       = SLOT_FIELD_W'(r_slot);
    result.claim_generation = r_gen;
    result.rewind_decoder   = r_rewind;
    result.frame_shown      = r_shown;
    result.shown_slot       = SLOT_FIELD_W'(displayed_slot);
    result.latest_frame     = frame_now;
    result.loops_seen       = r_loops;
    result.loop_total       = loop_counter;
    result.playback_ended   = r_ended;
  end

endmodule

// ===== hw/rtl/frame_slot_flip_pacer.sv =====
// ----------------------------------------------------------------------------
// frame_slot_flip_pacer
// Frame buffer pacer between a picture decoder and a display.
//
//   channel   handshake                  payload
//   item      item_valid / item_ready    item   (fsfp_pkg::item_t)
//   result    result_valid / result_ready result (fsfp_pkg::result_t)
//   config    cfg_write                  cfg_index, cfg_data
//
// One word at a time. Claim, complete, restart and a tick after playback ended
// raise result_valid on leaving the exec state; any other tick goes on to the
// clamp state and then pops due frames (at most MAX_CATCH_UP, one per cycle),
// unless the pending time stays below one frame period, before the result is flagged.
// The next word is accepted once the result is taken, in that same cycle.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "frame_slot_flip_pacer_assert.svh"

module frame_slot_flip_pacer #(
  parameter int MAX_CATCH_UP = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  fsfp_pkg::cfg_reg_t              cfg_index,
  input  logic [fsfp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  fsfp_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output fsfp_pkg::result_t               result
);
  import fsfp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       item_take;
  logic       shown_out;

  fsfp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .status       (status)
  );

  fsfp_datapath #(
    .MAX_CATCH_UP (MAX_CATCH_UP)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  assign item_take = item_valid && item_ready;
  assign shown_out = result_valid && result.frame_shown;

  `FSFP_ASSERT_IMP(a_take_free, item_take, !result_valid || result_ready, "result overrun")
  `FSFP_ASSERT_NEXT(a_gap_after_take, item_take, !result_valid, "result too early")
  `FSFP_ASSERT_IMP(a_shown_not_ended, shown_out, !result.playback_ended, "shown and ended")

endmodule

// ===== tb/frame_slot_flip_pacer_test.sv =====
// ----------------------------------------------------------------------------
// frame_slot_flip_pacer_test
// Self-checking bench for the frame slot flip pacer. A directed part walks
// slot claims, stale and failed completes, catch-up ticks, end of playback,
// restarts and generation wrap; random phases then run decoder-like traffic
// mixed with noise over several register settings and idle patterns. Every
// result word is checked field by field against an in-bench model.
// ----------------------------------------------------------------------------
module frame_slot_flip_pacer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fsfp_pkg::*;

  localparam int          NUM_SLOTS   = 4;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int          MAX_REPORTS = 100;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  item_valid;
  logic                  item_ready;
  item_t                 item;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result;

  int          errors = 0;
  int unsigned cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  logic [23:0] frame_seq = '0;

  result_t awaited_results[$];

  // pacer model state
  logic [2:0]        cfg_slots;
  logic [19:0]       cfg_period;
  slot_state_t       slot_st[NUM_SLOTS];
  logic [23:0]       slot_fr[NUM_SLOTS];
  logic              slot_lp[NUM_SLOTS];
  logic [7:0]        claim_tag[NUM_SLOTS];
  logic [1:0]        ready_q[NUM_SLOTS];
  logic [1:0]        q_head;
  logic [2:0]        q_count;
  logic [7:0]        gen_now;
  logic              rewind_due;
  logic              end_seen;
  logic              play_over;
  logic [1:0]        shown_now;
  logic [1:0]        retired_now;
  logic              retired_ok;
  int unsigned       pend_us;
  logic [23:0]       frame_now_p;
  logic [15:0]       loop_tot;
  logic [1:0]        last_grant;

  frame_slot_flip_pacer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void reset_pacer_model();
    cfg_slots   = SLOTS_IN_USE_RESET;
    cfg_period  = FRAME_PERIOD_RESET;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_st[i]   = SLOT_EMPTY;
      slot_fr[i]   = '0;
      slot_lp[i]   = 1'b0;
      claim_tag[i] = '0;
      ready_q[i]   = '0;
    end
    slot_st[0]  = SLOT_ON_SCREEN;
    q_head      = '0;
    q_count     = '0;
    gen_now     = '0;
    rewind_due  = 1'b0;
    end_seen    = 1'b0;
    play_over   = 1'b0;
    shown_now   = '0;
    retired_now = '0;
    retired_ok  = 1'b0;
    pend_us     = 0;
    frame_now_p = '0;
    loop_tot    = '0;
    last_grant  = '0;
  endfunction

  function automatic result_t advance_pacer(item_t w);
    result_t     r;
    int unsigned per, cap, due, taken, used, n;
    logic [1:0]  s, newest, tail;
    r = '0;
    case (w.operation)
      OP_CLAIM: begin
        if (rewind_due) begin
          rewind_due = 1'b0;
          r.rewind_decoder = 1'b1;
        end else if (!end_seen) begin
          n = (cfg_slots < NUM_SLOTS) ? cfg_slots : NUM_SLOTS;
          for (int i = 0; i < n; i++) begin
            if (slot_st[i] == SLOT_EMPTY) begin
              slot_st[i]         = SLOT_FILLING;
              claim_tag[i]       = gen_now;
              last_grant         = i[1:0];
              r.claim_granted    = 1'b1;
              r.claim_slot       = i[1:0];
              r.claim_generation = gen_now;
              break;
            end
          end
        end
      end
      OP_COMPLETE: begin
        if (slot_st[w.slot_index] == SLOT_FILLING) begin
          if (w.generation_tag != gen_now) begin
            slot_st[w.slot_index] = SLOT_EMPTY;
          end else if (w.decode_ok) begin
            slot_st[w.slot_index] = SLOT_QUEUED;
            slot_fr[w.slot_index] = w.frame_number;
            slot_lp[w.slot_index] = w.looped_flag;
            tail = q_head + q_count[1:0];
            ready_q[tail] = w.slot_index;
            q_count++;
          end else begin
            slot_st[w.slot_index] = SLOT_EMPTY;
            end_seen = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (!play_over) begin
          per = (cfg_period == 0) ? 1 : cfg_period;
          pend_us += w.elapsed_us;
          if (pend_us >= per) begin
            cap = 3 * per;
            if (pend_us > cap) pend_us = cap;
            due    = pend_us / per;
            taken  = 0;
            newest = '0;
            while (taken < due && q_count != 0) begin
              s = ready_q[q_head];
              q_head++;
              q_count--;
              if (taken != 0) slot_st[newest] = SLOT_EMPTY;
              newest = s;
              frame_now_p = slot_fr[s];
              if (slot_lp[s]) begin
                if (loop_tot != 16'hFFFF) loop_tot++;
                if (r.loops_seen != 2'd3) r.loops_seen++;
              end
              taken++;
            end
            if (taken == 0) begin
              if (end_seen && q_count == 0) begin
                play_over = 1'b1;
                pend_us = 0;
                r.playback_ended = 1'b1;
              end
            end else begin
              used = taken * per;
              pend_us = (pend_us > used) ? pend_us - used : 0;
              if (retired_ok) slot_st[retired_now] = SLOT_EMPTY;
              retired_now = shown_now;
              retired_ok  = 1'b1;
              slot_st[retired_now] = SLOT_PARKED;
              shown_now = newest;
              slot_st[newest] = SLOT_ON_SCREEN;
              r.frame_shown = 1'b1;
            end
          end
        end
      end
      OP_RESTART: begin
        gen_now++;
        rewind_due = 1'b1;
        end_seen = 1'b0;
        while (q_count != 0) begin
          s = ready_q[q_head];
          q_head++;
          q_count--;
          slot_st[s] = SLOT_EMPTY;
        end
        frame_now_p = '0;
        pend_us = 0;
        loop_tot = '0;
        play_over = 1'b0;
      end
      default: ;
    endcase
    r.shown_slot    = shown_now;
    r.latest_frame  = frame_now_p;
    r.loop_total    = loop_tot;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < MAX_REPORTS) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = awaited_results.pop_front();
        check_field("claim_granted", result.claim_granted, want.claim_granted);
        check_field("claim_slot", result.claim_slot, want.claim_slot);
        check_field("claim_generation", result.claim_generation, want.claim_generation);
        check_field("rewind_decoder", result.rewind_decoder, want.rewind_decoder);
        check_field("frame_shown", result.frame_shown, want.frame_shown);
        check_field("shown_slot", result.shown_slot, want.shown_slot);
        check_field("latest_frame", result.latest_frame, want.latest_frame);
        check_field("loops_seen", result.loops_seen, want.loops_seen);
        check_field("loop_total", result.loop_total, want.loop_total);
        check_field("playback_ended", result.playback_ended, want.playback_ended);
      end
    end
  end

  // result side: random stalls, plus a long hold when requested
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left--;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic push_word(item_t w);
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    awaited_results.push_back(advance_pacer(w));
    @(negedge clk);
  endtask

  task automatic idle_gap();
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    do @(negedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_SLOTS_IN_USE) cfg_slots = val[2:0];
    else cfg_period = val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic item_t make_word(op_t op, logic [19:0] el, logic [1:0] idx,
                                      logic [7:0] tag, logic ok, logic [23:0] fnum,
                                      logic lp);
    item_t w;
    w.operation      = op;
    w.elapsed_us     = el;
    w.slot_index     = idx;
    w.generation_tag = tag;
    w.decode_ok      = ok;
    w.frame_number   = fnum;
    w.looped_flag    = lp;
    return w;
  endfunction

  function automatic item_t random_item();
    logic [63:0] bits;
    item_t       w;
    bits = {$urandom, $urandom};
    w = bits[$bits(item_t)-1:0];
    return w;
  endfunction

  function automatic logic [19:0] tick_span();
    int unsigned per, e;
    per = (cfg_period == 0) ? 1 : cfg_period;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: e = per + $urandom_range(per / 16);
      5, 6:          e = per * $urandom_range(2, 3);
      7:             e = $urandom_range(per - 1);
      8:             e = 0;
      default:       e = $urandom_range(20'hFFFFF);
    endcase
    if (e > 20'hFFFFF) e = 20'hFFFFF;
    return e[19:0];
  endfunction

  function automatic int pick_decoding();
    int picks[$];
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_st[i] == SLOT_FILLING) picks.push_back(i);
    if (picks.size() == 0) return -1;
    return picks[$urandom_range(picks.size() - 1)];
  endfunction

  task automatic random_words(int count);
    item_t w;
    int    sel, idx;
    for (int k = 0; k < count; k++) begin
      w = random_item();
      if ($urandom_range(99) >= 15) begin
        sel = $urandom_range(99);
        idx = pick_decoding();
        if (sel < 3) begin
          w.operation = OP_RESTART;
        end else if (sel < 33) begin
          w.operation = OP_CLAIM;
        end else if (sel < 66 && idx >= 0) begin
          w.operation  = OP_COMPLETE;
          w.slot_index = idx[1:0];
          if ($urandom_range(99) < 92) w.generation_tag = claim_tag[idx];
          w.decode_ok = ($urandom_range(99) < 96);
          if ($urandom_range(3) != 0) begin
            w.frame_number = frame_seq;
            frame_seq++;
          end
          w.looped_flag = ($urandom_range(99) < 8);
        end else begin
          w.operation  = OP_TICK;
          w.elapsed_us = tick_span();
        end
      end
      push_word(w);
      idle_gap();
    end
  endtask

  task automatic test_directed_flow();
    push_word(make_word(OP_TICK, '0, '0, '0, 1'b0, '0, 1'b0));
    push_word(make_word(OP_TICK, 20'hFFFFF, 2'd3, 8'hFF, 1'b1, 24'hFFFFFF, 1'b1));
    repeat (4) push_word(make_word(OP_CLAIM, '0, '0, '0, 1'b0, '0, 1'b0));
    push_word(make_word(OP_COMPLETE, '0, 2'd1, 8'd0, 1'b1, 24'hFFFFFF, 1'b1));
    push_word(make_word(OP_COMPLETE, '0, 2'd2, 8'hFF, 1'b1, 24'h123456, 1'b0));
    push_word(make_word(OP_COMPLETE, '0, 2'd0, 8'd0, 1'b1, 24'h000001, 1'b0));
    push_word(make_word(OP_COMPLETE, '0, 2'd3, 8'd0, 1'b1, 24'h000000, 1'b0));
    push_word(make_word(OP_TICK, '0, '0, '0, 1'b0, '0, 1'b0));
    push_word(make_word(OP_CLAIM, '0, '0, '0, 1'b0, '0, 1'b0));
    push_word(make_word(OP_COMPLETE, '0, last_grant, gen_now, 1'b0, 24'hFFFFFF, 1'b1));
    push_word(make_word(OP_CLAIM, '0, '0, '0, 1'b0, '0, 1'b0));
    push_word(make_word(OP_TICK, 20'd33367, '0, '0, 1'b0, '0, 1'b0));
    push_word(make_word(OP_TICK, 20'hFFFFF, '0, '0, 1'b0, '0, 1'b0));
    push_word(make_word(OP_RESTART, '0, '0, '0, 1'b0, '0, 1'b0));
    push_word(make_word(OP_CLAIM, '0, '0, '0, 1'b0, '0, 1'b0));
    push_word(make_word(OP_CLAIM, '0, '0, '0, 1'b0, '0, 1'b0));
    push_word(make_word(OP_COMPLETE, '0, last_grant, gen_now, 1'b1, 24'd5, 1'b1));
    push_word(make_word(OP_RESTART, '0, '0, '0, 1'b0, '0, 1'b0));
    push_word(make_word(OP_CLAIM, '0, '0, '0, 1'b0, '0, 1'b0));
  endtask

  task automatic test_period_and_slot_extremes();
    drain();
    write_reg(CFG_FRAME_PERIOD, '0);
    write_reg(CFG_SLOTS_IN_USE, 20'd7);
    repeat (3) begin
      push_word(make_word(OP_CLAIM, '0, '0, '0, 1'b0, '0, 1'b0));
      push_word(make_word(OP_COMPLETE, '0, last_grant, gen_now, 1'b1, frame_seq, 1'b1));
      frame_seq++;
    end
    push_word(make_word(OP_TICK, '0, '0, '0, 1'b0, '0, 1'b0));
    push_word(make_word(OP_TICK, 20'd5, '0, '0, 1'b0, '0, 1'b0));
    drain();
    write_reg(CFG_SLOTS_IN_USE, '0);
    push_word(make_word(OP_CLAIM, '0, '0, '0, 1'b0, '0, 1'b0));
    push_word(make_word(OP_TICK, 20'd1, '0, '0, 1'b0, '0, 1'b0));
  endtask

  task automatic test_generation_wrap();
    int idx;
    drain();
    write_reg(CFG_SLOTS_IN_USE, 20'd4);
    repeat (255) push_word(make_word(OP_RESTART, '0, '0, '0, 1'b0, '0, 1'b0));
    push_word(make_word(OP_CLAIM, '0, '0, '0, 1'b0, '0, 1'b0));
    idx = pick_decoding();
    while (idx >= 0) begin
      push_word(make_word(OP_COMPLETE, '0, idx[1:0], claim_tag[idx], 1'b1, '0, 1'b0));
      idx = pick_decoding();
    end
    push_word(make_word(OP_CLAIM, '0, '0, '0, 1'b0, '0, 1'b0));
    push_word(make_word(OP_COMPLETE, '0, last_grant, gen_now, 1'b1, 24'h00ABCD, 1'b0));
  endtask

  task automatic test_random_phase(logic [2:0] slots, logic [19:0] period,
                                   int idle, int stall, int count);
    drain();
    write_reg(CFG_SLOTS_IN_USE, {17'd0, slots});
    write_reg(CFG_FRAME_PERIOD, period);
    idle_pct  = idle;
    stall_pct = stall;
    random_words(count);
  endtask

  task automatic test_result_holdoff();
    drain();
    idle_pct     = 0;
    stall_pct    = 0;
    hold_request = 400;
    random_words(40);
    drain();
  endtask

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_write  = 1'b0;
    cfg_index  = CFG_SLOTS_IN_USE;
    cfg_data   = '0;
    reset_pacer_model();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_flow();
    test_period_and_slot_extremes();
    test_generation_wrap();
    test_random_phase(3'd4, 20'd33367, 0, 0, 240);
    test_random_phase(3'd3, 20'd1000, 49, 0, 240);
    test_random_phase(3'd4, 20'd1000000, 0, 49, 240);
    test_random_phase(3'd7, 20'hFFFFF, 14, 14, 240);
    test_random_phase(3'd3, 20'd1000, 49, 49, 240);
    test_result_holdoff();

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/fsfp_pkg.sv
hw/rtl/fsfp_ctrl.sv
hw/rtl/fsfp_datapath.sv
hw/rtl/frame_slot_flip_pacer.sv
tb/frame_slot_flip_pacer_test.sv
